@@ sv/qmu_pkg.sv @@
// ----------------------------------------------------------------------------
// Quaternion math unit package
// Shared widths, action codes, the payload record that rides along the
// pipeline, and the component saturation function.
// ----------------------------------------------------------------------------
package qmu_pkg;

  localparam int unsigned Lanes     = 4;
  localparam int unsigned FracBits  = 20;
  localparam int unsigned NormGuard = 7;
  localparam int unsigned CompW     = 24;
  localparam int unsigned EpsW      = 21;
  localparam int unsigned ScalarW   = 32;
  localparam int unsigned SqW       = 2 * CompW + 1;       // sum of four squares
  localparam int unsigned DotW      = 2 * CompW + 2;       // signed sum of four products
  localparam int unsigned RadW      = 64;                  // square root radicand
  localparam int unsigned RootW     = RadW / 2;
  localparam int unsigned QuotW     = 26;                  // quotient bits per lane
  localparam int unsigned MagW      = QuotW + 1;
  localparam int unsigned LenW      = 26;
  localparam int unsigned NormShift = FracBits + NormGuard;
  localparam int unsigned InvShift  = 2 * FracBits + 1 - QuotW;

  localparam logic [2:0] ActNorm   = 3'd0;
  localparam logic [2:0] ActInv    = 3'd1;
  localparam logic [2:0] ActConj   = 3'd2;
  localparam logic [2:0] ActLen    = 3'd3;
  localparam logic [2:0] ActDot    = 3'd4;
  localparam logic [2:0] ActOrient = 3'd5;

  localparam logic [MagW-1:0] NegLim = MagW'(1) << (CompW - 1);
  localparam logic [MagW-1:0] PosLim = NegLim - 1'b1;

  typedef struct packed {
    logic                           sat;
    logic [CompW-1:0]               val;
  } sat_res_t;

  typedef struct packed {
    logic [2:0]                     act;
    logic [Lanes-1:0][CompW-1:0]    a;
    logic [SqW-1:0]                 s;
    logic                           near_zero;
    logic                           len_zero;
    logic                           orient;
    logic [ScalarW-1:0]             dot;
    logic                           dot_sat;
    logic [Lanes-1:0][CompW-1:0]    conj;
    logic                           conj_sat;
    logic [LenW-1:0]                len;
  } side_t;

  // Clamp a sign and magnitude pair into a 24-bit signed component
  function automatic sat_res_t sat_comp(input logic neg, input logic [MagW-1:0] mag);
    sat_res_t res;
    res.sat = 1'b0;
    res.val = '0;
    if (neg) begin
      if (mag > NegLim) begin
        res.sat = 1'b1;
        res.val = NegLim[CompW-1:0];
      end else begin
        res.val = CompW'(~mag + 1'b1);
      end
    end else begin
      if (mag > PosLim) begin
        res.sat = 1'b1;
        res.val = PosLim[CompW-1:0];
      end else begin
        res.val = mag[CompW-1:0];
      end
    end
    return res;
  endfunction

endpackage

@@ sv/qmu_if.sv @@
// ----------------------------------------------------------------------------
// Quaternion math unit channels
// Valid/ready channels for input items, result items and the epsilon write.
// ----------------------------------------------------------------------------
interface qmu_in_if;
  logic                               valid;
  logic                               ready;
  logic [2:0]                         action;
  logic signed [qmu_pkg::CompW-1:0]   a_x;
  logic signed [qmu_pkg::CompW-1:0]   a_y;
  logic signed [qmu_pkg::CompW-1:0]   a_z;
  logic signed [qmu_pkg::CompW-1:0]   a_w;
  logic signed [qmu_pkg::CompW-1:0]   b_x;
  logic signed [qmu_pkg::CompW-1:0]   b_y;
  logic signed [qmu_pkg::CompW-1:0]   b_z;
  logic signed [qmu_pkg::CompW-1:0]   b_w;

  modport source (output valid, action, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                  input ready);
  modport sink (input valid, action, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                output ready);
endinterface

interface qmu_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [qmu_pkg::CompW-1:0]   r_x;
  logic signed [qmu_pkg::CompW-1:0]   r_y;
  logic signed [qmu_pkg::CompW-1:0]   r_z;
  logic signed [qmu_pkg::CompW-1:0]   r_w;
  logic signed [qmu_pkg::ScalarW-1:0] scalar_out;
  logic                               match_flag;
  logic                               saturated;

  modport source (output valid, r_x, r_y, r_z, r_w, scalar_out, match_flag, saturated,
                  input ready);
  modport sink (input valid, r_x, r_y, r_z, r_w, scalar_out, match_flag, saturated,
                output ready);
endinterface

interface qmu_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [qmu_pkg::EpsW-1:0]           epsilon_threshold;

  modport source (output valid, epsilon_threshold, input ready);
  modport sink (input valid, epsilon_threshold, output ready);
endinterface

@@ sv/quaternion_math_unit.sv @@
// ----------------------------------------------------------------------------
// Quaternion math unit
// Normalize, inverse, conjugate, length, dot product and orientation test on
// signed Q4.20 quaternions, fully pipelined.
// Throughput: one item per cycle while the result is not held; the 32-stage
// square root and the divider's 26 quotient stages retire one bit per stage,
// and the whole pipeline stalls together.
// Reset: clears all valid bits and sets epsilon_threshold to 1.
// ----------------------------------------------------------------------------
module quaternion_math_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  qmu_cfg_if.sink      cfg_i,
  qmu_in_if.sink       in_i,
  qmu_out_if.source    out_o
);

  localparam int unsigned Lanes   = qmu_pkg::Lanes;
  localparam int unsigned CompW   = qmu_pkg::CompW;
  localparam int unsigned QuotW   = qmu_pkg::QuotW;
  localparam int unsigned MagW    = qmu_pkg::MagW;
  localparam int unsigned ScalarW = qmu_pkg::ScalarW;

  typedef struct packed {
    logic [Lanes-1:0][CompW-1:0] r;
    logic [ScalarW-1:0]          sc;
    logic                        match;
    logic                        sat;
  } out_t;

  logic                        en;
  logic [qmu_pkg::EpsW-1:0]    eps_q;

  // ---- epsilon register ----
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= qmu_pkg::EpsW'(1);
    end else if (cfg_i.valid) begin
      eps_q <= cfg_i.epsilon_threshold;
    end
  end

  // ---- advance the whole pipeline unless the result is held ----
  logic out_vld_q;
  out_t out_q;

  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // ---- input register ----
  logic                          s0_vld_q;
  logic [2:0]                    s0_act_q;
  logic [Lanes-1:0][CompW-1:0]   s0_a_q;
  logic [Lanes-1:0][CompW-1:0]   s0_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_act_q <= in_i.action;
      s0_a_q   <= {in_i.a_w, in_i.a_z, in_i.a_y, in_i.a_x};
      s0_b_q   <= {in_i.b_w, in_i.b_z, in_i.b_y, in_i.b_x};
    end
  end

  // ---- datapath ----
  logic                                fr_vld;
  qmu_pkg::side_t                      fr_side;
  logic                                sq_vld;
  qmu_pkg::side_t                      sq_side;
  logic [qmu_pkg::RootW-1:0]           sq_root;
  logic [qmu_pkg::RootW:0]             sq_rem;
  logic                                dv_vld;
  qmu_pkg::side_t                      dv_side;
  logic [Lanes-1:0][QuotW-1:0]         dv_quot;
  logic [Lanes-1:0]                    dv_ovf;

  qmu_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s0_vld_q),
    .act_i  (s0_act_q),
    .a_i    (s0_a_q),
    .b_i    (s0_b_q),
    .eps_i  (eps_q),
    .vld_o  (fr_vld),
    .side_o (fr_side)
  );

  qmu_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (fr_vld),
    .side_i (fr_side),
    .vld_o  (sq_vld),
    .side_o (sq_side),
    .root_o (sq_root),
    .rem_o  (sq_rem)
  );

  qmu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sq_vld),
    .side_i (sq_side),
    .root_i (sq_root),
    .rem_i  (sq_rem),
    .vld_o  (dv_vld),
    .side_o (dv_side),
    .quot_o (dv_quot),
    .ovf_o  (dv_ovf)
  );

  // ---- result select and clamp ----
  logic [MagW-1:0]       qmag [Lanes];
  logic                  qneg [Lanes];
  qmu_pkg::sat_res_t     qres [Lanes];
  qmu_pkg::sat_res_t     one_res;
  logic                  div_sat;
  out_t                  out_d;

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      if (dv_ovf[i]) begin
        qmag[i] = '1;
      end else if (dv_side.act == qmu_pkg::ActNorm) begin
        qmag[i] = {1'b0, dv_quot[i]};
      end else begin
        qmag[i] = ({1'b0, dv_quot[i]} + 1'b1) >> 1;
      end
      if (dv_side.act == qmu_pkg::ActNorm || i == Lanes - 1) begin
        qneg[i] = dv_side.a[i][CompW-1];
      end else begin
        qneg[i] = !dv_side.a[i][CompW-1] && (dv_side.a[i] != '0);
      end
      qres[i] = qmu_pkg::sat_comp(qneg[i], qmag[i]);
    end
    div_sat = qres[0].sat | qres[1].sat | qres[2].sat | qres[3].sat;
    one_res = qmu_pkg::sat_comp(1'b0, MagW'(1) << qmu_pkg::FracBits);

    out_d = '0;
    unique case (dv_side.act)
      qmu_pkg::ActNorm: begin
        if (dv_side.near_zero) begin
          out_d.r     = dv_side.a;
          out_d.match = 1'b1;
        end else begin
          for (int i = 0; i < Lanes; i++) out_d.r[i] = qres[i].val;
          out_d.sat = div_sat;
        end
      end
      qmu_pkg::ActInv: begin
        if (dv_side.near_zero) begin
          out_d.r[Lanes-1] = one_res.val;
          out_d.sat        = one_res.sat;
          out_d.match      = 1'b1;
        end else begin
          for (int i = 0; i < Lanes; i++) out_d.r[i] = qres[i].val;
          out_d.sat = div_sat;
        end
      end
      qmu_pkg::ActConj: begin
        out_d.r   = dv_side.conj;
        out_d.sat = dv_side.conj_sat;
      end
      qmu_pkg::ActLen: begin
        if (dv_side.len_zero) begin
          out_d.match = 1'b1;
        end else begin
          out_d.sc = ScalarW'(dv_side.len);
        end
      end
      qmu_pkg::ActDot: begin
        out_d.sc  = dv_side.dot;
        out_d.sat = dv_side.dot_sat;
      end
      qmu_pkg::ActOrient: begin
        out_d.match = dv_side.orient;
      end
      default: begin
        out_d = '0;
      end
    endcase
  end

  // ---- output register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.r_x        = out_q.r[0];
  assign out_o.r_y        = out_q.r[1];
  assign out_o.r_z        = out_q.r[2];
  assign out_o.r_w        = out_q.r[3];
  assign out_o.scalar_out = out_q.sc;
  assign out_o.match_flag = out_q.match;
  assign out_o.saturated  = out_q.sat;

  // ---- assertions ----
  // scalar results never carry a quaternion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.sc != '0) |-> (out_q.r == '0))
    else $error("scalar result with nonzero quaternion");

  // no path both matches and clamps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_q.match && out_q.sat))
    else $error("match and saturated set together");

  // a held result freezes the input stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en) |=> $stable(s0_vld_q))
    else $error("input stage moved during stall");

endmodule

@@ sv/qmu_front.sv @@
// ----------------------------------------------------------------------------
// Quaternion math unit front end
// Three stages: squares, products and orientation compares; the two sums;
// near-zero tests, dot rounding and the conjugate.
// ----------------------------------------------------------------------------
module qmu_front (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            en_i,
  input  logic                                            vld_i,
  input  logic [2:0]                                      act_i,
  input  logic [qmu_pkg::Lanes-1:0][qmu_pkg::CompW-1:0]   a_i,
  input  logic [qmu_pkg::Lanes-1:0][qmu_pkg::CompW-1:0]   b_i,
  input  logic [qmu_pkg::EpsW-1:0]                        eps_i,
  output logic                                            vld_o,
  output qmu_pkg::side_t                                  side_o
);

  localparam int unsigned Lanes = qmu_pkg::Lanes;
  localparam int unsigned CompW = qmu_pkg::CompW;
  localparam int unsigned DotW  = qmu_pkg::DotW;
  localparam int unsigned SqW   = qmu_pkg::SqW;
  localparam int unsigned ScalarW = qmu_pkg::ScalarW;
  localparam logic [DotW:0] SMinMag = (DotW + 1)'(1) << (ScalarW - 1);
  localparam logic [DotW:0] SMaxMag = SMinMag - 1'b1;

  // ---- stage 1: squares, products, orientation compares ----
  logic [CompW-1:0]              mag1 [Lanes];
  logic signed [CompW:0]         dif1 [Lanes];
  logic signed [CompW:0]         sum1 [Lanes];
  logic [CompW:0]                dmag1 [Lanes];
  logic [CompW:0]                smag1 [Lanes];
  logic [Lanes-1:0]              eq1, opp1;
  logic [2*CompW-1:0]            sq_d [Lanes];
  logic signed [2*CompW-1:0]     prod_d [Lanes];

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      mag1[i]   = a_i[i][CompW-1] ? (~a_i[i] + 1'b1) : a_i[i];
      sq_d[i]   = (2*CompW)'(mag1[i]) * (2*CompW)'(mag1[i]);
      prod_d[i] = $signed(a_i[i]) * $signed(b_i[i]);
      dif1[i]   = $signed({a_i[i][CompW-1], a_i[i]}) - $signed({b_i[i][CompW-1], b_i[i]});
      sum1[i]   = $signed({a_i[i][CompW-1], a_i[i]}) + $signed({b_i[i][CompW-1], b_i[i]});
      dmag1[i]  = dif1[i][CompW] ? (~dif1[i] + 1'b1) : dif1[i];
      smag1[i]  = sum1[i][CompW] ? (~sum1[i] + 1'b1) : sum1[i];
      eq1[i]    = !(dmag1[i] > (CompW + 1)'(eps_i));
      opp1[i]   = !(smag1[i] > (CompW + 1)'(eps_i));
    end
  end

  logic                          s1_vld_q;
  logic [2:0]                    s1_act_q;
  logic [Lanes-1:0][CompW-1:0]   s1_a_q;
  logic [2*CompW-1:0]            s1_sq_q [Lanes];
  logic signed [2*CompW-1:0]     s1_prod_q [Lanes];
  logic                          s1_orient_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_act_q    <= act_i;
      s1_a_q      <= a_i;
      s1_sq_q     <= sq_d;
      s1_prod_q   <= prod_d;
      s1_orient_q <= (&eq1) || (&opp1);
    end
  end

  // ---- stage 2: squared length and raw dot sum ----
  logic [SqW-1:0]                s_d;
  logic signed [DotW-1:0]        d_d;

  always_comb begin
    s_d = SqW'(s1_sq_q[0]) + SqW'(s1_sq_q[1]) + SqW'(s1_sq_q[2]) + SqW'(s1_sq_q[3]);
    d_d = DotW'(s1_prod_q[0]) + DotW'(s1_prod_q[1])
        + DotW'(s1_prod_q[2]) + DotW'(s1_prod_q[3]);
  end

  logic                          s2_vld_q;
  logic [2:0]                    s2_act_q;
  logic [Lanes-1:0][CompW-1:0]   s2_a_q;
  logic [SqW-1:0]                s2_s_q;
  logic signed [DotW-1:0]        s2_d_q;
  logic                          s2_orient_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en_i) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_act_q    <= s1_act_q;
      s2_a_q      <= s1_a_q;
      s2_s_q      <= s_d;
      s2_d_q      <= d_d;
      s2_orient_q <= s1_orient_q;
    end
  end

  // ---- stage 3: thresholds, dot rounding, conjugate ----
  logic [SqW-1:0]                eps_sq;
  logic [DotW-1:0]               dmag3;
  logic [DotW:0]                 drnd3;
  logic [CompW-1:0]              mag3 [Lanes];
  qmu_pkg::sat_res_t             cres3 [Lanes];
  qmu_pkg::side_t                side_d;

  always_comb begin
    eps_sq = SqW'({eps_i, (qmu_pkg::FracBits)'(0)});
    dmag3  = s2_d_q[DotW-1] ? (~s2_d_q + 1'b1) : s2_d_q;
    drnd3  = ((DotW + 1)'(dmag3) + ((DotW + 1)'(1) << (qmu_pkg::FracBits - 1)))
             >> qmu_pkg::FracBits;

    side_d           = '0;
    side_d.act       = s2_act_q;
    side_d.a         = s2_a_q;
    side_d.s         = s2_s_q;
    side_d.near_zero = (s2_s_q < eps_sq) || (s2_s_q == '0);
    side_d.len_zero  = (s2_s_q <= eps_sq);
    side_d.orient    = s2_orient_q;

    // round the dot magnitude, then clamp to the scalar range
    if (s2_d_q[DotW-1]) begin
      if (drnd3 > SMinMag) begin
        side_d.dot_sat = 1'b1;
        side_d.dot     = ScalarW'(SMinMag);
      end else begin
        side_d.dot     = ScalarW'(~drnd3 + 1'b1);
      end
    end else begin
      if (drnd3 > SMaxMag) begin
        side_d.dot_sat = 1'b1;
        side_d.dot     = ScalarW'(SMaxMag);
      end else begin
        side_d.dot     = ScalarW'(drnd3);
      end
    end

    // negate the vector part; w passes through
    for (int i = 0; i < Lanes; i++) begin
      mag3[i]  = s2_a_q[i][CompW-1] ? (~s2_a_q[i] + 1'b1) : s2_a_q[i];
      cres3[i] = qmu_pkg::sat_comp(!s2_a_q[i][CompW-1] && (s2_a_q[i] != '0),
                                   qmu_pkg::MagW'(mag3[i]));
    end
    for (int i = 0; i < Lanes - 1; i++) begin
      side_d.conj[i] = cres3[i].val;
    end
    side_d.conj[Lanes-1] = s2_a_q[Lanes-1];
    side_d.conj_sat      = cres3[0].sat | cres3[1].sat | cres3[2].sat;
  end

  logic                          s3_vld_q;
  qmu_pkg::side_t                s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en_i) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_side_q <= side_d;
    end
  end

  assign vld_o  = s3_vld_q;
  assign side_o = s3_side_q;

endmodule

@@ sv/qmu_sqrt.sv @@
// ----------------------------------------------------------------------------
// Quaternion math unit square root
// Digit-by-digit integer square root, one root bit per pipeline stage.
// Normalize takes the root of S with seven guard bits, the rest of S.
// ----------------------------------------------------------------------------
module qmu_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         vld_i,
  input  qmu_pkg::side_t               side_i,
  output logic                         vld_o,
  output qmu_pkg::side_t               side_o,
  output logic [qmu_pkg::RootW-1:0]    root_o,
  output logic [qmu_pkg::RootW:0]      rem_o
);

  localparam int unsigned RadW  = qmu_pkg::RadW;
  localparam int unsigned RootW = qmu_pkg::RootW;
  localparam int unsigned Steps = RootW;

  logic [RadW-1:0]       rad;
  logic                  vld_q  [Steps];
  qmu_pkg::side_t        side_q [Steps];
  logic [RadW-1:0]       rad_q  [Steps];
  logic [RootW-1:0]      root_q [Steps];
  logic [RootW:0]        rem_q  [Steps];

  // pick the radicand: S shifted up for guard bits, or S itself
  always_comb begin
    if (side_i.act == qmu_pkg::ActNorm) begin
      rad = RadW'({side_i.s, (2 * qmu_pkg::NormGuard)'(0)});
    end else begin
      rad = RadW'(side_i.s);
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic                 vld_in;
    qmu_pkg::side_t       side_in;
    logic [RadW-1:0]      rad_in;
    logic [RootW-1:0]     root_in;
    logic [RootW:0]       rem_in;
    logic [RootW+2:0]     t;
    logic [RootW+1:0]     trial;
    logic                 ge;

    if (k == 0) begin : g_first
      assign vld_in  = vld_i;
      assign side_in = side_i;
      assign rad_in  = rad;
      assign root_in = '0;
      assign rem_in  = '0;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign side_in = side_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign root_in = root_q[k-1];
      assign rem_in  = rem_q[k-1];
    end

    // bring down the next bit pair and try the subtract
    always_comb begin
      t     = {rem_in, rad_in[2*(Steps-1-k)+1 -: 2]};
      trial = {root_in, 2'b01};
      ge    = (t >= (RootW + 3)'(trial));
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        rad_q[k]  <= rad_in;
        root_q[k] <= {root_in[RootW-2:0], ge};
        rem_q[k]  <= ge ? (RootW + 1)'(t - (RootW + 3)'(trial)) : t[RootW:0];
      end
    end
  end

  assign vld_o  = vld_q[Steps-1];
  assign side_o = side_q[Steps-1];
  assign root_o = root_q[Steps-1];
  assign rem_o  = rem_q[Steps-1];

endmodule

@@ sv/qmu_div.sv @@
// ----------------------------------------------------------------------------
// Quaternion math unit divider
// One setup stage, then a restoring divider per lane that retires one
// quotient bit per stage. Normalize divides by the root, inverse by S.
// ----------------------------------------------------------------------------
module qmu_div (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            en_i,
  input  logic                                            vld_i,
  input  qmu_pkg::side_t                                  side_i,
  input  logic [qmu_pkg::RootW-1:0]                       root_i,
  input  logic [qmu_pkg::RootW:0]                         rem_i,
  output logic                                            vld_o,
  output qmu_pkg::side_t                                  side_o,
  output logic [qmu_pkg::Lanes-1:0][qmu_pkg::QuotW-1:0]   quot_o,
  output logic [qmu_pkg::Lanes-1:0]                       ovf_o
);

  localparam int unsigned Lanes = qmu_pkg::Lanes;
  localparam int unsigned CompW = qmu_pkg::CompW;
  localparam int unsigned SqW   = qmu_pkg::SqW;
  localparam int unsigned QuotW = qmu_pkg::QuotW;
  localparam int unsigned LenW  = qmu_pkg::LenW;
  localparam int unsigned HiW   = CompW + qmu_pkg::InvShift;
  localparam int unsigned NumW  = CompW + qmu_pkg::NormShift;

  typedef struct packed {
    logic [SqW-1:0]   rem;
    logic [QuotW-1:0] lo;
    logic [QuotW-1:0] q;
    logic             ovf;
  } lane_t;

  typedef lane_t [Lanes-1:0] lanes_t;

  logic                  vld_q  [QuotW+1];
  qmu_pkg::side_t        side_q [QuotW+1];
  logic [SqW-1:0]        dvs_q  [QuotW+1];
  lanes_t                ln_q   [QuotW+1];

  // ---- setup: rounded length, divisor, numerator split ----
  qmu_pkg::side_t        side_p;
  logic [SqW-1:0]        dvs_p;
  lanes_t                ln_p;
  logic [CompW-1:0]      mag  [Lanes];
  logic [NumW-1:0]       num  [Lanes];
  logic [HiW-1:0]        hi   [Lanes];

  always_comb begin
    side_p     = side_i;
    side_p.len = LenW'(root_i) + LenW'(rem_i > {1'b0, root_i});
    dvs_p      = (side_i.act == qmu_pkg::ActNorm) ? SqW'(root_i) : side_i.s;
    for (int i = 0; i < Lanes; i++) begin
      mag[i] = side_i.a[i][CompW-1] ? (~side_i.a[i] + 1'b1) : side_i.a[i];
      num[i] = (NumW'(mag[i]) << qmu_pkg::NormShift) + NumW'(root_i >> 1);
      if (side_i.act == qmu_pkg::ActNorm) begin
        hi[i]       = HiW'(num[i] >> QuotW);
        ln_p[i].lo  = num[i][QuotW-1:0];
      end else begin
        hi[i]       = HiW'(mag[i]) << qmu_pkg::InvShift;
        ln_p[i].lo  = '0;
      end
      ln_p[i].ovf = (SqW'(hi[i]) >= dvs_p);
      ln_p[i].rem = SqW'(hi[i]);
      ln_p[i].q   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_p;
      dvs_q[0]  <= dvs_p;
      ln_q[0]   <= ln_p;
    end
  end

  // ---- quotient stages, most significant bit first ----
  for (genvar j = 0; j < QuotW; j++) begin : g_step
    lanes_t            ln_d;
    logic [SqW:0]      t  [Lanes];
    logic [Lanes-1:0]  ge;

    always_comb begin
      for (int i = 0; i < Lanes; i++) begin
        t[i]         = {ln_q[j][i].rem, ln_q[j][i].lo[QuotW-1-j]};
        ge[i]        = (t[i] >= {1'b0, dvs_q[j]});
        ln_d[i]      = ln_q[j][i];
        ln_d[i].rem  = ge[i] ? SqW'(t[i] - {1'b0, dvs_q[j]}) : t[i][SqW-1:0];
        ln_d[i].q    = {ln_q[j][i].q[QuotW-2:0], ge[i]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[j+1] <= side_q[j];
        dvs_q[j+1]  <= dvs_q[j];
        ln_q[j+1]   <= ln_d;
      end
    end
  end

  assign vld_o  = vld_q[QuotW];
  assign side_o = side_q[QuotW];

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      quot_o[i] = ln_q[QuotW][i].q;
      ovf_o[i]  = ln_q[QuotW][i].ovf;
    end
  end

endmodule
